@@ src/wfsd_pkg.sv @@
// wfsd_pkg: shared types and constants for the wall follow steering decider
// used by every module of the block, depends on nothing
`default_nettype none

package wfsd_pkg;

    localparam int unsigned DIST_W  = 8;
    localparam int unsigned SIDE_W  = 11;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic signed [SIDE_W-1:0] SIDE_CLOSE   = -11'sd1;
    localparam logic signed [SIDE_W-1:0] SIDE_UNKNOWN = 11'sd777;
    localparam logic signed [SIDE_W-1:0] SIDE_FAR     = 11'sd999;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CLOSE   = 2'd1,
        ST_FAR     = 2'd2,
        ST_UNKNOWN = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CMD_FWD   = 2'd0,
        CMD_LEFT  = 2'd1,
        CMD_RIGHT = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRONT_CLEAR_LIMIT = 3'd0,
        REG_WALL_TARGET       = 3'd1,
        REG_WALL_FLOOR        = 3'd2,
        REG_TURN_MARGIN       = 3'd3,
        REG_SKEW_MARGIN       = 3'd4,
        REG_SPIN_LIMIT        = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [DIST_W-1:0] front_clear_limit;
        logic [DIST_W-1:0] wall_target;
        logic [DIST_W-1:0] wall_floor;
        logic [DIST_W-1:0] turn_margin;
        logic [DIST_W-1:0] skew_margin;
        logic [DIST_W-1:0] spin_limit;
    } t_cfg;

    typedef struct packed {
        t_status           back_status;
        logic [DIST_W-1:0] back_dist;
        t_status           front_status;
        logic [DIST_W-1:0] front_dist;
        logic signed [SIDE_W-1:0] fused;
    } t_side;

    typedef struct packed {
        t_side right;
        t_side left;
        logic  blocked;
    } t_item;

endpackage

`default_nettype wire

@@ src/wall_follow_steering_decider_top.sv @@
// wall_follow_steering_decider_top: configuration registers, front, queue and back
// depends on wfsd_pkg, wfsd_front, wfsd_queue, wfsd_back
//
// Usage: the input channel (i_in_valid / o_in_stall) takes one frame of five
// range readings with status codes; the output channel (o_out_valid /
// i_out_stall) returns one transaction per frame: drive command, followed side
// and fused range of that side. A frame is accepted when valid is high and
// stall is low. The configuration channel (i_cfg_valid / o_cfg_ready) writes
// register i_cfg_index with i_cfg_data; it is always ready, indexes above five
// are dropped. Write it only while no frame is in flight.
// An accepted frame is written into the queue, then into the result register.
// Throughput: one frame per cycle, set by the decision stage, while not stalled.
// A two-entry queue sits between the front and the decision stage, so the
// input keeps flowing while a result waits; o_in_stall follows the queue's
// full flag, and the queue fills only while i_out_stall holds the result.
// Reset (synchronous, active low) loads the register defaults, selects the
// right wall, clears the spin counter and empties the queue and output.
`default_nettype none

module wall_follow_steering_decider_top
    import wfsd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [1:0]           i_right_back_status,
    input  wire logic [DIST_W-1:0]    i_right_back_dist,
    input  wire logic [1:0]           i_right_front_status,
    input  wire logic [DIST_W-1:0]    i_right_front_dist,
    input  wire logic [1:0]           i_left_back_status,
    input  wire logic [DIST_W-1:0]    i_left_back_dist,
    input  wire logic [1:0]           i_left_front_status,
    input  wire logic [DIST_W-1:0]    i_left_front_dist,
    input  wire logic [1:0]           i_ahead_status,
    input  wire logic [DIST_W-1:0]    i_ahead_dist,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [1:0]                o_drive_command,
    output logic                      o_follow_right,
    output logic signed [SIDE_W-1:0]  o_side_range,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DIST_W-1:0]    i_cfg_data
);

    t_cfg  r_cfg;
    t_item front_item;
    t_item q_item;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;
    logic  push;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;
    assign push        = i_in_valid && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.front_clear_limit <= 8'd150;
            r_cfg.wall_target       <= 8'd100;
            r_cfg.wall_floor        <= 8'd50;
            r_cfg.turn_margin       <= 8'd10;
            r_cfg.skew_margin       <= 8'd5;
            r_cfg.spin_limit        <= 8'd10;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_FRONT_CLEAR_LIMIT: r_cfg.front_clear_limit <= i_cfg_data;
                REG_WALL_TARGET:       r_cfg.wall_target       <= i_cfg_data;
                REG_WALL_FLOOR:        r_cfg.wall_floor        <= i_cfg_data;
                REG_TURN_MARGIN:       r_cfg.turn_margin       <= i_cfg_data;
                REG_SKEW_MARGIN:       r_cfg.skew_margin       <= i_cfg_data;
                REG_SPIN_LIMIT:        r_cfg.spin_limit        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    wfsd_front u_front (
        .i_right_back_status  (i_right_back_status),
        .i_right_back_dist    (i_right_back_dist),
        .i_right_front_status (i_right_front_status),
        .i_right_front_dist   (i_right_front_dist),
        .i_left_back_status   (i_left_back_status),
        .i_left_back_dist     (i_left_back_dist),
        .i_left_front_status  (i_left_front_status),
        .i_left_front_dist    (i_left_front_dist),
        .i_ahead_status       (i_ahead_status),
        .i_ahead_dist         (i_ahead_dist),
        .i_front_clear_limit  (r_cfg.front_clear_limit),
        .o_item               (front_item)
    );

    wfsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    wfsd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_q_valid       (q_valid),
        .i_q_item        (q_item),
        .o_pop           (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_drive_command (o_drive_command),
        .o_follow_right  (o_follow_right),
        .o_side_range    (o_side_range)
    );

endmodule

`default_nettype wire

@@ src/wfsd_front.sv @@
// wfsd_front: fuses each side's sensor pair and classifies the path ahead
// depends on wfsd_pkg
`default_nettype none

module wfsd_front
    import wfsd_pkg::*;
(
    input  wire logic [1:0]        i_right_back_status,
    input  wire logic [DIST_W-1:0] i_right_back_dist,
    input  wire logic [1:0]        i_right_front_status,
    input  wire logic [DIST_W-1:0] i_right_front_dist,
    input  wire logic [1:0]        i_left_back_status,
    input  wire logic [DIST_W-1:0] i_left_back_dist,
    input  wire logic [1:0]        i_left_front_status,
    input  wire logic [DIST_W-1:0] i_left_front_dist,
    input  wire logic [1:0]        i_ahead_status,
    input  wire logic [DIST_W-1:0] i_ahead_dist,
    input  wire logic [DIST_W-1:0] i_front_clear_limit,
    output t_item                  o_item
);

    function automatic logic signed [SIDE_W-1:0] fuse_side(
        input t_status           sb,
        input logic [DIST_W-1:0] db,
        input t_status           sf,
        input logic [DIST_W-1:0] df
    );
        logic [DIST_W:0] sum;
        logic signed [SIDE_W-1:0] v;
        sum = {1'b0, db} + {1'b0, df};
        if (sb == ST_OK && sf == ST_OK) begin
            v = $signed({{(SIDE_W-DIST_W){1'b0}}, sum[DIST_W:1]});
        end else if (sb == ST_OK) begin
            v = (sf == ST_CLOSE) ? SIDE_CLOSE
                                 : $signed({{(SIDE_W-DIST_W){1'b0}}, db});
        end else if (sf == ST_OK) begin
            v = (sb == ST_CLOSE) ? SIDE_CLOSE
                                 : $signed({{(SIDE_W-DIST_W){1'b0}}, df});
        end else if (sb == ST_CLOSE || sf == ST_CLOSE) begin
            v = SIDE_CLOSE;
        end else if (sb == ST_FAR || sf == ST_FAR) begin
            v = SIDE_FAR;
        end else begin
            v = SIDE_UNKNOWN;
        end
        return v;
    endfunction

    always_comb begin
        o_item.right.back_status  = t_status'(i_right_back_status);
        o_item.right.back_dist    = i_right_back_dist;
        o_item.right.front_status = t_status'(i_right_front_status);
        o_item.right.front_dist   = i_right_front_dist;
        o_item.right.fused        = fuse_side(t_status'(i_right_back_status),
                                              i_right_back_dist,
                                              t_status'(i_right_front_status),
                                              i_right_front_dist);
        o_item.left.back_status   = t_status'(i_left_back_status);
        o_item.left.back_dist     = i_left_back_dist;
        o_item.left.front_status  = t_status'(i_left_front_status);
        o_item.left.front_dist    = i_left_front_dist;
        o_item.left.fused         = fuse_side(t_status'(i_left_back_status),
                                              i_left_back_dist,
                                              t_status'(i_left_front_status),
                                              i_left_front_dist);
        o_item.blocked = (i_ahead_status == ST_CLOSE) ||
                         (i_ahead_status == ST_OK && i_ahead_dist < i_front_clear_limit);
    end

endmodule

`default_nettype wire

@@ src/wfsd_queue.sv @@
// wfsd_queue: two-entry queue between the classifying front and the deciding back
// depends on wfsd_pkg
`default_nettype none

module wfsd_queue
    import wfsd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_item     i_item,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_item     o_item
);

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

@@ src/wfsd_back.sv @@
// wfsd_back: side choice, steering decision tree, spin counter and result register
// depends on wfsd_pkg
`default_nettype none

module wfsd_back
    import wfsd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_cfg      i_cfg,
    input  wire logic i_q_valid,
    input  t_item     i_q_item,
    output logic      o_pop,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output logic [1:0]              o_drive_command,
    output logic                    o_follow_right,
    output logic signed [SIDE_W-1:0] o_side_range
);

    logic r_right_chosen;
    logic n_right_chosen;
    logic [7:0] r_spin_count;
    logic [7:0] n_spin_count;
    logic r_out_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic signed [SIDE_W-1:0] r_side;

    t_side sel;
    t_cmd toward;
    t_cmd away;
    logic spin;
    logic clr;
    logic spin_ok;
    logic signed [DIST_W+1:0] d_bf;
    logic signed [DIST_W+1:0] d_fb;
    logic signed [DIST_W+1:0] lim;
    logic signed [DIST_W+1:0] mdiff;
    logic signed [SIDE_W-1:0] pref;
    logic signed [SIDE_W-1:0] minr;

    assign o_pop = i_q_valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_right_chosen = r_right_chosen;
        if (i_q_item.right.fused < i_q_item.left.fused) begin
            n_right_chosen = 1'b1;
        end else if (i_q_item.left.fused < i_q_item.right.fused) begin
            n_right_chosen = 1'b0;
        end
        sel    = n_right_chosen ? i_q_item.right : i_q_item.left;
        toward = n_right_chosen ? CMD_RIGHT : CMD_LEFT;
        away   = n_right_chosen ? CMD_LEFT : CMD_RIGHT;
        d_bf   = $signed({2'b00, sel.back_dist}) - $signed({2'b00, sel.front_dist});
        d_fb   = $signed({2'b00, sel.front_dist}) - $signed({2'b00, sel.back_dist});
        lim    = $signed({2'b00, i_cfg.turn_margin});
        mdiff  = $signed({2'b00, i_cfg.skew_margin});
        pref   = $signed({{(SIDE_W-DIST_W){1'b0}}, i_cfg.wall_target});
        minr   = $signed({{(SIDE_W-DIST_W){1'b0}}, i_cfg.wall_floor});
        spin_ok = (r_spin_count <= i_cfg.spin_limit);
    end

    // decision tree
    always_comb begin
        n_cmd = CMD_FWD;
        spin  = 1'b0;
        clr   = 1'b0;
        if (i_q_item.blocked) begin
            clr   = 1'b1;
            n_cmd = (sel.fused < SIDE_UNKNOWN) ? away : toward;
        end else if (sel.back_status == ST_OK && sel.front_status == ST_OK) begin
            if (sel.fused > pref) begin
                if (d_bf < lim) begin
                    n_cmd = toward;
                    spin  = 1'b1;
                end
            end else if (sel.fused <= minr) begin
                if (d_fb < lim) begin
                    n_cmd = away;
                    spin  = 1'b1;
                end
            end else if (d_fb > mdiff) begin
                n_cmd = toward;
            end else if (d_bf > mdiff) begin
                n_cmd = away;
            end
        end else if (sel.front_status == ST_OK) begin
            if (sel.back_status == ST_CLOSE) begin
                n_cmd = toward;
            end else if (sel.back_status == ST_FAR) begin
                n_cmd = away;
            end
        end else if (sel.back_status == ST_OK) begin
            if (sel.front_status == ST_CLOSE) begin
                n_cmd = away;
            end else if (sel.front_status == ST_FAR) begin
                n_cmd = toward;
            end
        end else if (sel.back_status == ST_CLOSE && sel.front_status == ST_CLOSE) begin
            if (spin_ok) begin
                n_cmd = away;
                spin  = 1'b1;
            end
        end else if (sel.back_status == ST_FAR && sel.front_status == ST_FAR) begin
            if (spin_ok) begin
                n_cmd = toward;
                spin  = 1'b1;
            end
        end else if (sel.back_status == ST_CLOSE) begin
            n_cmd = toward;
        end else if (sel.front_status == ST_CLOSE) begin
            n_cmd = away;
        end else if (sel.back_status == ST_FAR) begin
            if (spin_ok) begin
                n_cmd = toward;
                spin  = 1'b1;
            end
        end
    end

    always_comb begin
        n_spin_count = r_spin_count;
        if (clr) begin
            n_spin_count = 8'd0;
        end else if (spin && r_spin_count != 8'hFF) begin
            n_spin_count = r_spin_count + 8'd1;
        end
        if (sel.fused <= pref && sel.fused != SIDE_CLOSE) begin
            n_spin_count = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right_chosen <= 1'b1;
            r_spin_count   <= 8'd0;
            r_out_valid    <= 1'b0;
        end else begin
            if (o_pop) begin
                r_right_chosen <= n_right_chosen;
                r_spin_count   <= n_spin_count;
                r_out_valid    <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd  <= n_cmd;
            r_side <= sel.fused;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_drive_command = r_cmd;
    assign o_follow_right  = r_right_chosen;
    assign o_side_range    = r_side;

endmodule

`default_nettype wire
